// ----- design/tlc_pkg.sv -----
// ----------------------------------------------------------------------------
// tlc_pkg: shared types and constants of the timed lock controller
// Mode codes, register indexes, the item and result records and the
// fixed-point helpers that the pipeline stages use.
// ----------------------------------------------------------------------------
package tlc_pkg;

  typedef enum logic [1:0] {
    MODE_OPEN    = 2'd0,
    MODE_CONFIG  = 2'd1,
    MODE_CONFIRM = 2'd2,
    MODE_CLOSED  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_PULSE_MS      = 2'd0,
    CFG_SAVE_INTERVAL = 2'd1,
    CFG_STEP_SECONDS  = 2'd2,
    CFG_MAX_SECONDS   = 2'd3
  } cfg_index_t;

  localparam int CfgDataWidth = 20;

  localparam logic [15:0] PULSE_MS_RESET      = 16'd1000;
  localparam logic [19:0] SAVE_INTERVAL_RESET = 20'd900000;
  localparam logic [11:0] STEP_SECONDS_RESET  = 12'd600;
  localparam logic [16:0] MAX_SECONDS_RESET   = 17'd86400;
  localparam logic [16:0] DURATION_RESET      = 17'd30;

  // Saturation point of the time-since-last-save counter.
  localparam logic [19:0] SINCE_SAVE_MAX = 20'hFFFFF;

  // Rounding bias for a ceiling division by one thousand.
  localparam logic [27:0] ROUND_UP_MS = 28'd999;

  // ceil(2^32 / 125): exact floor division by 125 for any 25-bit dividend.
  localparam logic [25:0] RECIP_125 = 26'd34359739;

  typedef struct packed {
    logic [15:0] pulse_ms;
    logic [19:0] save_interval_ms;
    logic [11:0] step_seconds;
    logic [16:0] max_seconds;
  } cfg_t;

  typedef struct packed {
    logic        tick;
    logic        plus_pressed;
    logic        minus_pressed;
    logic        ok_pressed;
    logic        restore_valid;
    logic        restore_nonzero;
    logic [17:0] restore_seconds;  // ceil(restore_ms / 1000)
  } item_t;

  typedef struct packed {
    mode_t       mode;
    logic        relay_on;
    logic [16:0] duration_seconds;
    logic [26:0] remaining_ms;
    logic        save_request;
    logic [26:0] save_value_ms;
    logic        clear_request;
  } result_t;

  // Seconds to milliseconds as 1024 - 32 + 8; modulo arithmetic keeps it exact.
  function automatic logic [26:0] seconds_to_ms(input logic [16:0] seconds);
    logic [26:0] s;
    s = {10'd0, seconds};
    return (s << 10) - (s << 5) + (s << 3);
  endfunction

endpackage

// ----- design/tlc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tlc_cfg_regs: configuration register file
// Holds the four setup registers, written through a simple enable port.
// ----------------------------------------------------------------------------
module tlc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [tlc_pkg::CfgDataWidth-1:0]  cfg_data,
  output tlc_pkg::cfg_t                     cfg
);
  import tlc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_ms         <= PULSE_MS_RESET;
      cfg.save_interval_ms <= SAVE_INTERVAL_RESET;
      cfg.step_seconds     <= STEP_SECONDS_RESET;
      cfg.max_seconds      <= MAX_SECONDS_RESET;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_PULSE_MS:      cfg.pulse_ms         <= cfg_data[15:0];
        CFG_SAVE_INTERVAL: cfg.save_interval_ms <= cfg_data[19:0];
        CFG_STEP_SECONDS:  cfg.step_seconds     <= cfg_data[11:0];
        CFG_MAX_SECONDS:   cfg.max_seconds      <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/tlc_in_stage.sv -----
// ----------------------------------------------------------------------------
// tlc_in_stage: input register
// Captures one item and precomputes the rounded-up restore time in seconds.
// ----------------------------------------------------------------------------
module tlc_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           tick,
  input  logic           plus_pressed,
  input  logic           minus_pressed,
  input  logic           ok_pressed,
  input  logic           restore_valid,
  input  logic [26:0]    restore_ms,
  input  logic           advance,
  output logic           item_valid,
  output tlc_pkg::item_t item
);
  import tlc_pkg::*;

  logic [27:0] biased_ms;
  logic [50:0] product;
  logic [17:0] seconds_ceil;

  // floor((ms + 999) / 1000) = floor(floor((ms + 999) / 8) / 125).
  assign biased_ms    = {1'b0, restore_ms} + ROUND_UP_MS;
  assign product      = 51'(biased_ms[27:3]) * 51'(RECIP_125);
  assign seconds_ceil = product[49:32];

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.tick            <= tick;
      item.plus_pressed    <= plus_pressed;
      item.minus_pressed   <= minus_pressed;
      item.ok_pressed      <= ok_pressed;
      item.restore_valid   <= restore_valid;
      item.restore_nonzero <= (restore_ms != 27'd0);
      item.restore_seconds <= seconds_ceil;
    end
  end

endmodule

// ----- design/tlc_step.sv -----
// ----------------------------------------------------------------------------
// tlc_step: controller state and per-item update
// Applies one item to the mode, duration, countdown and relay pulse state.
// ----------------------------------------------------------------------------
module tlc_step (
  input  logic             clk,
  input  logic             rst,
  input  tlc_pkg::cfg_t    cfg,
  input  logic             advance,
  input  tlc_pkg::item_t   item,
  output tlc_pkg::result_t result
);
  import tlc_pkg::*;

  mode_t       mode, mode_next;
  logic [16:0] duration, duration_next;
  logic        timer_running, timer_running_next;
  logic [26:0] countdown, countdown_next;
  logic [19:0] since_save, since_save_next;
  logic        pulse_active, pulse_active_next;
  logic [15:0] pulse_left, pulse_left_next;
  logic        relay, relay_next;

  logic        save_req;
  logic [26:0] save_val;
  logic        clear_req;
  logic        start;
  logic [16:0] start_seconds;
  logic [17:0] sum;

  always_comb begin
    mode_next          = mode;
    duration_next      = duration;
    timer_running_next = timer_running;
    countdown_next     = countdown;
    since_save_next    = since_save;
    pulse_active_next  = pulse_active;
    pulse_left_next    = pulse_left;
    relay_next         = relay;
    save_req           = 1'b0;
    save_val           = '0;
    clear_req          = 1'b0;
    start              = 1'b0;
    start_seconds      = '0;
    sum                = '0;

    // Elapsed millisecond.
    if (item.tick) begin
      if (timer_running_next) begin
        if (countdown_next != '0) countdown_next = countdown_next - 27'd1;
        if (since_save_next != SINCE_SAVE_MAX) since_save_next = since_save_next + 20'd1;
      end
      if (pulse_active_next && pulse_left_next != '0) begin
        pulse_left_next = pulse_left_next - 16'd1;
      end
    end

    if (item.restore_valid) begin
      timer_running_next = 1'b0;
      countdown_next     = '0;
      since_save_next    = '0;
      if (item.restore_nonzero) begin
        start         = 1'b1;
        start_seconds = (item.restore_seconds > {1'b0, cfg.max_seconds}) ?
                        cfg.max_seconds : item.restore_seconds[16:0];
        mode_next     = MODE_CLOSED;
      end else begin
        mode_next = MODE_OPEN;
      end
    end else begin
      // Buttons act in order; each sees the mode the previous one left.
      if (item.plus_pressed) begin
        if (mode_next == MODE_OPEN) mode_next = MODE_CONFIG;
        if (mode_next == MODE_CONFIG) begin
          sum = {1'b0, duration_next} + {6'd0, cfg.step_seconds};
          duration_next = (sum < {1'b0, cfg.max_seconds}) ? sum[16:0] : cfg.max_seconds;
        end
      end
      if (item.minus_pressed) begin
        case (mode_next)
          MODE_OPEN: mode_next = MODE_CONFIG;
          MODE_CONFIG: begin
            if (duration_next == '0) begin
              mode_next = MODE_OPEN;
            end else if (duration_next > {5'd0, cfg.step_seconds}) begin
              duration_next = duration_next - {5'd0, cfg.step_seconds};
            end else begin
              duration_next = '0;
            end
          end
          MODE_CONFIRM: mode_next = MODE_CONFIG;
          default: ;
        endcase
      end
      if (item.ok_pressed) begin
        case (mode_next)
          MODE_OPEN: begin
            relay_next        = 1'b1;
            pulse_active_next = 1'b1;
            pulse_left_next   = cfg.pulse_ms;
          end
          MODE_CONFIG: mode_next = MODE_CONFIRM;
          MODE_CONFIRM: begin
            relay_next        = 1'b0;
            pulse_active_next = 1'b0;
            pulse_left_next   = '0;
            start             = 1'b1;
            start_seconds     = duration_next;
            mode_next         = MODE_CLOSED;
          end
          default: ;
        endcase
      end
    end

    if (start) begin
      timer_running_next = 1'b1;
      countdown_next     = seconds_to_ms(start_seconds);
      since_save_next    = '0;
      if (start_seconds != '0) begin
        save_req = 1'b1;
        save_val = countdown_next;
      end
    end

    if (timer_running_next) begin
      if (since_save_next >= cfg.save_interval_ms) begin
        save_req        = 1'b1;
        save_val        = countdown_next;
        since_save_next = '0;
      end
      // Expiry, including a zero-length lock that ends at once.
      if (countdown_next == '0) begin
        timer_running_next = 1'b0;
        since_save_next    = '0;
        relay_next         = 1'b1;
        pulse_active_next  = 1'b1;
        pulse_left_next    = cfg.pulse_ms;
        mode_next          = MODE_OPEN;
        clear_req          = 1'b1;
      end
    end

    if (pulse_active_next && pulse_left_next == '0) begin
      relay_next        = 1'b0;
      pulse_active_next = 1'b0;
    end
  end

  always_comb begin
    result.mode             = mode_next;
    result.relay_on         = relay_next;
    result.duration_seconds = duration_next;
    result.remaining_ms     = timer_running_next ? countdown_next : '0;
    result.save_request     = save_req;
    result.save_value_ms    = save_req ? save_val : '0;
    result.clear_request    = clear_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_OPEN;
      duration      <= DURATION_RESET;
      timer_running <= 1'b0;
      countdown     <= '0;
      since_save    <= '0;
      pulse_active  <= 1'b0;
      pulse_left    <= '0;
      relay         <= 1'b0;
    end else if (advance) begin
      mode          <= mode_next;
      duration      <= duration_next;
      timer_running <= timer_running_next;
      countdown     <= countdown_next;
      since_save    <= since_save_next;
      pulse_active  <= pulse_active_next;
      pulse_left    <= pulse_left_next;
      relay         <= relay_next;
    end
  end

endmodule

// ----- design/tlc_out_reg.sv -----
// ----------------------------------------------------------------------------
// tlc_out_reg: result register
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
module tlc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  tlc_pkg::result_t result_in,
  input  logic             out_ready,
  output logic             out_valid,
  output tlc_pkg::result_t result_q
);
  import tlc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_in;
    end
  end

endmodule

// ----- design/timed_lock_controller_unit.sv -----
// ----------------------------------------------------------------------------
// timed_lock_controller_unit: three-button timed lock controller
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle unless the result channel stalls; the step
// logic between the two registers closes the whole state update combinationally.
// Reset (synchronous, active high) restores the default configuration, open
// mode with a 30 second duration, and empties both pipeline registers.
// ----------------------------------------------------------------------------
module timed_lock_controller_unit (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [tlc_pkg::CfgDataWidth-1:0]  cfg_data,
  // Input item channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              tick,
  input  logic                              plus_pressed,
  input  logic                              minus_pressed,
  input  logic                              ok_pressed,
  input  logic                              restore_valid,
  input  logic [26:0]                       restore_ms,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        mode,
  output logic                              relay_on,
  output logic [16:0]                       duration_seconds,
  output logic [26:0]                       remaining_ms,
  output logic                              save_request,
  output logic [26:0]                       save_value_ms,
  output logic                              clear_request
);
  import tlc_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t step_result;
  result_t result_q;

  // The held item moves into the step logic whenever the result register is
  // empty or its current result is being transferred out in this cycle. The
  // input register refills in the same cycle, so items flow back to back.
  assign advance = item_valid && (!out_valid || out_ready);

  tlc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register; it also rounds a restored time up to whole seconds so
  // that the step stage only has to clamp and scale it.
  tlc_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .tick          (tick),
    .plus_pressed  (plus_pressed),
    .minus_pressed (minus_pressed),
    .ok_pressed    (ok_pressed),
    .restore_valid (restore_valid),
    .restore_ms    (restore_ms),
    .advance       (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  // Controller state; it is committed only when an item advances.
  tlc_step u_step (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .item    (item),
    .result  (step_result)
  );

  // Result register parting the controller from the downstream side.
  tlc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result_in (step_result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .result_q  (result_q)
  );

  assign mode             = result_q.mode;
  assign relay_on         = result_q.relay_on;
  assign duration_seconds = result_q.duration_seconds;
  assign remaining_ms     = result_q.remaining_ms;
  assign save_request     = result_q.save_request;
  assign save_value_ms    = result_q.save_value_ms;
  assign clear_request    = result_q.clear_request;

endmodule
